[src/buddy_page_allocator_top_defines.svh]
// Assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTH
// checked from reset release onwards
`define BPA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("buddy allocator check failed");
// checked during reset as well
`define BPA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("buddy allocator check failed");
`else
`define BPA_ASSERT(name, prop)
`define BPA_ASSERT_ALWAYS(name, prop)
`endif
`endif

[src/bpa_pkg.sv]
// Shared constants, codes and helpers of the buddy page allocator
package bpa_pkg;
  localparam int unsigned TOP_RANK_DEF   = 16;
  localparam int unsigned POOL_DEPTH_DEF = 32768;
  localparam logic [15:0] POOL_RESET     = 16'd32768;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_COUNT = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVAL   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  // pages in a block of rank r (r >= 1)
  function automatic logic [16:0] blk_size(input logic [4:0] r);
    blk_size = 17'd1 << (r - 5'd1);
  endfunction
endpackage

[src/buddy_page_allocator_top.sv]
// Buddy page allocator: free lists, page marks and the command sequencer
// One command at a time under a sequencer; the mark and clear steps share one index adder.
// Reads of the link and mark memories are registered, so a list walk reads and then
// steps per block; an allocation pops, writes back and pushes both halves per split,
// then marks the block handed out one page a cycle; a free clears the block one page a
// cycle, then each merge scans the buddy page by page and walks that rank's free list; a
// query of a free page scans and walks rank by rank from the largest; a count walks
// the list. After reset and after every pool_pages write a clearing pass over all
// POOL_DEPTH pages plus up to TOP_RANK rebuild pushes runs before the first command.
// Results wait in an output register, so a new command is taken while one is pending.
`include "buddy_page_allocator_top_defines.svh"
module buddy_page_allocator_top
  import bpa_pkg::*;
#(
  parameter int unsigned TOP_RANK   = TOP_RANK_DEF,
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] pool_pages_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  rank_i,
  input  logic [15:0] page_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] value_o
);
  localparam int unsigned RW = $clog2(TOP_RANK + 1);
  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_RBSEL    = 5'd1;
  localparam logic [4:0] S_RBPUSH   = 5'd2;
  localparam logic [4:0] S_IDLE     = 5'd3;
  localparam logic [4:0] S_A_SRCH   = 5'd4;
  localparam logic [4:0] S_POP      = 5'd5;
  localparam logic [4:0] S_POP_WB   = 5'd6;
  localparam logic [4:0] S_SPLIT1   = 5'd7;
  localparam logic [4:0] S_SPLIT2   = 5'd8;
  localparam logic [4:0] S_MARK     = 5'd9;
  localparam logic [4:0] S_PG_RD    = 5'd10;
  localparam logic [4:0] S_PG_CHK   = 5'd11;
  localparam logic [4:0] S_FCLR     = 5'd12;
  localparam logic [4:0] S_MG       = 5'd13;
  localparam logic [4:0] S_BF_RD    = 5'd14;
  localparam logic [4:0] S_BF_CHK   = 5'd15;
  localparam logic [4:0] S_UL       = 5'd16;
  localparam logic [4:0] S_ULPOP    = 5'd17;
  localparam logic [4:0] S_ULPOP_WB = 5'd18;
  localparam logic [4:0] S_UL_RD    = 5'd19;
  localparam logic [4:0] S_UL_CHK   = 5'd20;
  localparam logic [4:0] S_UL_FIX   = 5'd21;
  localparam logic [4:0] S_MG2      = 5'd22;
  localparam logic [4:0] S_FPUSH    = 5'd23;
  localparam logic [4:0] S_Q_R      = 5'd24;
  localparam logic [4:0] S_W_STEP   = 5'd25;
  localparam logic [4:0] S_W_RD     = 5'd26;
  localparam logic [4:0] S_OUT      = 5'd27;

  logic [4:0]          state_q, state_d;
  logic [15:0]         pool_q, pool_d;
  logic [15:0]         head_q [TOP_RANK+1];
  logic [15:0]         head_d [TOP_RANK+1];
  logic [TOP_RANK:0]   hok_q, hok_d;
  logic [RW-1:0]       rk_q, rk_d, tr_q, tr_d;
  logic [16:0]         idx_q, idx_d, rem_q, rem_d, aux_q, aux_d;
  logic [15:0]         cur_q, cur_d, base_q, base_d, cnt_q, cnt_d, page_q, page_d;
  logic                wok_q, wok_d, found_q, found_d;
  logic [1:0]          cmd_q, cmd_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [1:0]          res_st_q, res_st_d, st_q, st_d;
  logic [15:0]         res_val_q, res_val_d, val_q, val_d;
  logic                ov_q, ov_d;

  // link memory: {end-of-list flag inverted, next head page}
  logic [16:0]   nl_mem [POOL_DEPTH];
  logic          nl_we;
  logic [AW-1:0] nl_wa, nl_ra;
  logic [16:0]   nl_wd, nl_rd;
  // page mark memory: signed rank
  logic [5:0]    pm_mem [POOL_DEPTH];
  logic          pm_we;
  logic [AW-1:0] pm_wa, pm_ra;
  logic [5:0]    pm_wd, pm_rd;

  always_ff @(posedge clk_i) begin
    if (nl_we) nl_mem[nl_wa] <= nl_wd;
    nl_rd <= nl_mem[nl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) pm_mem[pm_wa] <= pm_wd;
    pm_rd <= pm_mem[pm_ra];
  end

  logic [16:0] pages, size, sum_a;
  logic [RW-1:0] rb_rank;
  logic rank_ok;
  logic pm_pos;

  assign pages = (17'(pool_q) > 17'(POOL_DEPTH)) ? 17'(POOL_DEPTH) : 17'(pool_q);
  assign size = blk_size(5'(rk_q));
  assign rank_ok = (rank_i != 5'd0) && (6'(rank_i) <= 6'(TOP_RANK));
  assign pm_pos = !pm_rd[5] && (pm_rd != 6'd0);

  // largest rank that still fits the remaining pages
  always_comb begin
    rb_rank = RW'(1);
    for (int r = 1; r <= TOP_RANK; r++) begin
      if (blk_size(5'(r)) <= rem_q) rb_rank = RW'(r);
    end
  end
  assign sum_a = idx_q + aux_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign value_o     = val_q;

  always_comb begin
    state_d = state_q;  pool_d = pool_q;  hok_d = hok_q;
    for (int i = 0; i <= TOP_RANK; i++) head_d[i] = head_q[i];
    rk_d = rk_q;  tr_d = tr_q;  idx_d = idx_q;  rem_d = rem_q;  aux_d = aux_q;
    cur_d = cur_q;  base_d = base_q;  cnt_d = cnt_q;  page_d = page_q;
    wok_d = wok_q;  found_d = found_q;  cmd_d = cmd_q;  clr_d = clr_q;
    res_st_d = res_st_q;  res_val_d = res_val_q;
    st_d = st_q;  val_d = val_q;  ov_d = ov_q;
    nl_we = 1'b0;  nl_wa = '0;  nl_wd = '0;  nl_ra = '0;
    pm_we = 1'b0;  pm_wa = '0;  pm_wd = '0;  pm_ra = '0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      S_CLR: begin
        pm_we = 1'b1;
        pm_wa = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(POOL_DEPTH - 1)) begin
          idx_d = '0;
          rem_d = pages;
          state_d = S_RBSEL;
        end
      end
      S_RBSEL: begin
        if (rem_q == '0) begin
          state_d = S_IDLE;
        end else begin
          rk_d = rb_rank;
          state_d = S_RBPUSH;
        end
      end
      S_RBPUSH: begin
        nl_we = 1'b1;
        nl_wa = idx_q[AW-1:0];
        nl_wd = {hok_q[rk_q], head_q[rk_q]};
        head_d[rk_q] = idx_q[15:0];
        hok_d[rk_q] = 1'b1;
        idx_d = idx_q + size;
        rem_d = rem_q - size;
        state_d = S_RBSEL;
      end
      S_IDLE: begin
        pm_ra = page_index_i[AW-1:0];
        if (in_valid_i) begin
          cmd_d = command_i;
          page_d = page_index_i;
          res_val_d = '0;
          unique case (command_i)
            CMD_ALLOC, CMD_COUNT: begin
              if (!rank_ok) begin
                res_st_d = ST_INVAL;
                state_d = S_OUT;
              end else begin
                rk_d = rank_i[RW-1:0];
                tr_d = rank_i[RW-1:0];
                if (command_i == CMD_ALLOC) begin
                  state_d = S_A_SRCH;
                end else begin
                  cur_d = head_q[rank_i[RW-1:0]];
                  wok_d = hok_q[rank_i[RW-1:0]];
                  base_d = '1;
                  cnt_d = '0;
                  aux_d = '0;
                  found_d = 1'b0;
                  state_d = S_W_STEP;
                end
              end
            end
            default: begin
              if (17'(page_index_i) >= pages) begin
                res_st_d = ST_INVAL;
                state_d = S_OUT;
              end else begin
                state_d = S_PG_RD;
              end
            end
          endcase
        end
      end
      S_A_SRCH: begin
        if (hok_q[rk_q]) begin
          state_d = S_POP;
        end else if (rk_q == RW'(TOP_RANK)) begin
          res_st_d = ST_NOSPACE;
          res_val_d = '0;
          state_d = S_OUT;
        end else begin
          rk_d = rk_q + RW'(1);
        end
      end
      S_POP: begin
        nl_ra = head_q[rk_q][AW-1:0];
        idx_d = 17'(head_q[rk_q]);
        state_d = S_POP_WB;
      end
      S_POP_WB: begin
        head_d[rk_q] = nl_rd[15:0];
        hok_d[rk_q] = nl_rd[16];
        aux_d = '0;
        if (rk_q > tr_q) begin
          rk_d = rk_q - RW'(1);
          state_d = S_SPLIT1;
        end else begin
          state_d = S_MARK;
        end
      end
      S_SPLIT1: begin
        // upper half goes on first so the lower half ends at the head
        nl_we = 1'b1;
        nl_wa = AW'(idx_q + size);
        nl_wd = {hok_q[rk_q], head_q[rk_q]};
        head_d[rk_q] = 16'(idx_q + size);
        hok_d[rk_q] = 1'b1;
        state_d = S_SPLIT2;
      end
      S_SPLIT2: begin
        nl_we = 1'b1;
        nl_wa = idx_q[AW-1:0];
        nl_wd = {1'b1, head_q[rk_q]};
        head_d[rk_q] = idx_q[15:0];
        state_d = S_POP;
      end
      S_MARK: begin
        pm_we = 1'b1;
        pm_wa = sum_a[AW-1:0];
        pm_wd = (aux_q == '0) ? 6'(tr_q) : -6'(tr_q);
        aux_d = aux_q + 17'd1;
        if (aux_q == size - 17'd1) begin
          res_st_d = ST_OK;
          res_val_d = idx_q[15:0];
          state_d = S_OUT;
        end
      end
      S_PG_RD: begin
        // hold the page address so the mark is still there next cycle
        pm_ra = page_q[AW-1:0];
        state_d = S_PG_CHK;
      end
      S_PG_CHK: begin
        if (pm_pos) begin
          if (cmd_q == CMD_FREE) begin
            rk_d = pm_rd[RW-1:0];
            idx_d = 17'(page_q);
            aux_d = '0;
            state_d = S_FCLR;
          end else begin
            res_st_d = ST_OK;
            res_val_d = 16'(pm_rd);
            state_d = S_OUT;
          end
        end else if (cmd_q == CMD_FREE) begin
          res_st_d = ST_INVAL;
          state_d = S_OUT;
        end else begin
          rk_d = RW'(TOP_RANK);
          state_d = S_Q_R;
        end
      end
      S_FCLR: begin
        pm_we = 1'b1;
        pm_wa = sum_a[AW-1:0];
        aux_d = aux_q + 17'd1;
        if (aux_q == size - 17'd1) state_d = S_MG;
      end
      S_MG: begin
        if (rk_q == RW'(TOP_RANK) || ((idx_q ^ size) + size) > pages) begin
          state_d = S_FPUSH;
        end else begin
          base_d = 16'(idx_q ^ size);
          aux_d = '0;
          state_d = S_BF_RD;
        end
      end
      S_BF_RD: begin
        pm_ra = AW'(17'(base_q) + aux_q);
        state_d = S_BF_CHK;
      end
      S_BF_CHK: begin
        if (pm_rd != 6'd0) begin
          if (cmd_q == CMD_FREE) begin
            state_d = S_FPUSH;
          end else if (rk_q == RW'(1)) begin
            res_st_d = ST_INVAL;
            state_d = S_OUT;
          end else begin
            rk_d = rk_q - RW'(1);
            state_d = S_Q_R;
          end
        end else if (aux_q == size - 17'd1) begin
          if (cmd_q == CMD_FREE) begin
            state_d = S_UL;
          end else begin
            cur_d = head_q[rk_q];
            wok_d = hok_q[rk_q];
            cnt_d = '0;
            aux_d = '0;
            found_d = 1'b0;
            state_d = S_W_STEP;
          end
        end else begin
          aux_d = aux_q + 17'd1;
          state_d = S_BF_RD;
        end
      end
      S_UL: begin
        aux_d = '0;
        cur_d = head_q[rk_q];
        if (!hok_q[rk_q]) state_d = S_MG2;
        else if (head_q[rk_q] == base_q) state_d = S_ULPOP;
        else state_d = S_UL_RD;
      end
      S_ULPOP: begin
        nl_ra = head_q[rk_q][AW-1:0];
        state_d = S_ULPOP_WB;
      end
      S_ULPOP_WB: begin
        head_d[rk_q] = nl_rd[15:0];
        hok_d[rk_q] = nl_rd[16];
        state_d = S_MG2;
      end
      S_UL_RD: begin
        nl_ra = cur_q[AW-1:0];
        state_d = S_UL_CHK;
      end
      S_UL_CHK: begin
        if (!nl_rd[16]) begin
          state_d = S_MG2;
        end else if (nl_rd[15:0] == base_q) begin
          nl_ra = base_q[AW-1:0];
          state_d = S_UL_FIX;
        end else begin
          cur_d = nl_rd[15:0];
          aux_d = aux_q + 17'd1;
          state_d = (aux_q == 17'(POOL_DEPTH - 1)) ? S_MG2 : S_UL_RD;
        end
      end
      S_UL_FIX: begin
        // bypass the buddy: predecessor takes over its link
        nl_we = 1'b1;
        nl_wa = cur_q[AW-1:0];
        nl_wd = nl_rd;
        state_d = S_MG2;
      end
      S_MG2: begin
        if (17'(base_q) < idx_q) idx_d = 17'(base_q);
        rk_d = rk_q + RW'(1);
        state_d = S_MG;
      end
      S_FPUSH: begin
        nl_we = 1'b1;
        nl_wa = idx_q[AW-1:0];
        nl_wd = {hok_q[rk_q], head_q[rk_q]};
        head_d[rk_q] = idx_q[15:0];
        hok_d[rk_q] = 1'b1;
        res_st_d = ST_OK;
        res_val_d = '0;
        state_d = S_OUT;
      end
      S_Q_R: begin
        if (((17'(page_q) & ~(size - 17'd1)) + size) > pages) begin
          if (rk_q == RW'(1)) begin
            res_st_d = ST_INVAL;
            state_d = S_OUT;
          end else begin
            rk_d = rk_q - RW'(1);
          end
        end else begin
          base_d = 16'(17'(page_q) & ~(size - 17'd1));
          aux_d = '0;
          state_d = S_BF_RD;
        end
      end
      S_W_STEP: begin
        if (!wok_q || aux_q == 17'(POOL_DEPTH)) begin
          if (cmd_q == CMD_COUNT) begin
            res_st_d = ST_OK;
            res_val_d = cnt_q;
            state_d = S_OUT;
          end else if (found_q) begin
            res_st_d = ST_OK;
            res_val_d = 16'(rk_q);
            state_d = S_OUT;
          end else if (rk_q == RW'(1)) begin
            res_st_d = ST_INVAL;
            state_d = S_OUT;
          end else begin
            rk_d = rk_q - RW'(1);
            state_d = S_Q_R;
          end
        end else begin
          if (cmd_q == CMD_QUERY && cur_q == base_q) found_d = 1'b1;
          if (cnt_q != 16'hFFFF) cnt_d = cnt_q + 16'd1;
          aux_d = aux_q + 17'd1;
          nl_ra = cur_q[AW-1:0];
          state_d = S_W_RD;
        end
      end
      S_W_RD: begin
        wok_d = nl_rd[16];
        cur_d = nl_rd[15:0];
        state_d = S_W_STEP;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          st_d = res_st_q;
          val_d = (res_st_q == ST_OK) ? res_val_q : 16'd0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
        clr_d = '0;
      end
    endcase

    // a pool size transaction restarts the rebuild
    if (cfg_valid_i) begin
      pool_d = pool_pages_i;
      hok_d = '0;
      clr_d = '0;
      state_d = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      pool_q <= POOL_RESET;
      hok_q <= '0;
      clr_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pool_q <= pool_d;
      hok_q <= hok_d;
      clr_q <= clr_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= TOP_RANK; i++) head_q[i] <= head_d[i];
    rk_q <= rk_d;  tr_q <= tr_d;  idx_q <= idx_d;  rem_q <= rem_d;  aux_q <= aux_d;
    cur_q <= cur_d;  base_q <= base_d;  cnt_q <= cnt_d;  page_q <= page_d;
    wok_q <= wok_d;  found_q <= found_d;  cmd_q <= cmd_d;
    res_st_q <= res_st_d;  res_val_q <= res_val_d;
    st_q <= st_d;  val_q <= val_d;
  end

  `BPA_ASSERT(a_one_at_a_time, (in_valid_i && in_ready_o && !cfg_valid_i) |=> !in_ready_o)
  `BPA_ASSERT(a_cfg_rebuilds, (cfg_valid_i && cfg_ready_o) |=> (state_q == S_CLR))
  `BPA_ASSERT(a_pop_nonempty, (state_q == S_POP) |-> hok_q[rk_q])
  `BPA_ASSERT(a_err_zero_value, (out_valid_o && status_o != ST_OK) |-> (value_o == 16'd0))
  `BPA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o)
endmodule

[tb/testbench.sv]
// Self-checking testbench for the buddy page allocator: directed and random command streams
module testbench
  import bpa_pkg::*;
();

  localparam int unsigned NPAGES    = POOL_DEPTH_DEF;
  localparam int unsigned NRANKS    = TOP_RANK_DEF;
  localparam int unsigned MAX_CYCLE = 12_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] pool_pages_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  command_i;
  logic [4:0]  rank_i;
  logic [15:0] page_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] value_o;

  buddy_page_allocator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .pool_pages_i (pool_pages_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .rank_i       (rank_i),
    .page_index_i (page_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .value_o      (value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // allocator shadow state
  int unsigned pool_size;
  int unsigned fl_head    [NRANKS+1];
  bit          fl_head_ok [NRANKS+1];
  int unsigned fl_next    [NPAGES];
  bit          fl_next_ok [NPAGES];
  int          pg_mark    [NPAGES];

  logic [1:0]  exp_status_q[$];
  logic [15:0] exp_value_q[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  function automatic int unsigned bsize(int unsigned r);
    return 1 << (r - 1);
  endfunction

  function automatic void fl_push(int unsigned idx, int unsigned r);
    if (idx >= NPAGES) return;
    fl_next[idx]    = fl_head[r];
    fl_next_ok[idx] = fl_head_ok[r];
    fl_head[r]      = idx;
    fl_head_ok[r]   = 1'b1;
  endfunction

  function automatic int unsigned fl_pop(int unsigned r);
    int unsigned idx;
    idx = fl_head[r];
    if (idx < NPAGES) begin
      fl_head[r]    = fl_next[idx];
      fl_head_ok[r] = fl_next_ok[idx];
    end else begin
      fl_head_ok[r] = 1'b0;
    end
    return idx;
  endfunction

  function automatic void fl_unlink(int unsigned idx, int unsigned r);
    int unsigned prv, cur;
    if (!fl_head_ok[r]) return;
    if (fl_head[r] == idx) begin
      void'(fl_pop(r));
      return;
    end
    prv = fl_head[r];
    for (int unsigned n = 0; n < NPAGES; n++) begin
      if (prv >= NPAGES || !fl_next_ok[prv]) return;
      cur = fl_next[prv];
      if (cur == idx) begin
        if (cur < NPAGES) begin
          fl_next[prv]    = fl_next[cur];
          fl_next_ok[prv] = fl_next_ok[cur];
        end else begin
          fl_next_ok[prv] = 1'b0;
        end
        return;
      end
      prv = cur;
    end
  endfunction

  function automatic int unsigned fl_walk(int unsigned r, int unsigned target,
                                          output bit found);
    int unsigned cnt, cur;
    bit ok;
    cnt = 0;
    ok = fl_head_ok[r];
    cur = fl_head[r];
    found = 1'b0;
    for (int unsigned n = 0; n < NPAGES && ok; n++) begin
      if (cur == target) found = 1'b1;
      if (cnt < 16'hFFFF) cnt++;
      if (cur >= NPAGES) break;
      ok  = fl_next_ok[cur];
      cur = fl_next[cur];
    end
    return cnt;
  endfunction

  function automatic bit span_free(int unsigned start, int unsigned size);
    for (int unsigned i = 0; i < size; i++)
      if (start + i >= NPAGES || pg_mark[start+i] != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void mark_span(int unsigned start, int unsigned r, bit alloc);
    for (int unsigned i = 0; i < bsize(r); i++) begin
      if (start + i >= NPAGES) return;
      pg_mark[start+i] = alloc ? ((i == 0) ? int'(r) : -int'(r)) : 0;
    end
  endfunction

  function automatic void rebuild_pool(logic [15:0] pages);
    int unsigned left, idx, r;
    pool_size = (pages > NPAGES) ? NPAGES : pages;
    for (int unsigned i = 0; i < NPAGES; i++) begin
      pg_mark[i] = 0;
      fl_next[i] = 0;
      fl_next_ok[i] = 1'b0;
    end
    for (int unsigned i = 0; i <= NRANKS; i++) begin
      fl_head[i] = 0;
      fl_head_ok[i] = 1'b0;
    end
    left = pool_size;
    idx = 0;
    while (left > 0) begin
      r = NRANKS;
      while (r > 1 && bsize(r) > left) r--;
      fl_push(idx, r);
      idx += bsize(r);
      left -= bsize(r);
    end
  endfunction

  function automatic void run_command(logic [1:0] cmd, logic [4:0] rank, logic [15:0] page,
                                      output logic [1:0] st, output logic [15:0] val);
    int unsigned lr, idx, cr, sz, bud, start, v;
    bit rank_ok, found;
    st = ST_INVAL;
    v = 0;
    rank_ok = rank >= 1 && rank <= NRANKS;
    case (cmd)
      CMD_ALLOC: begin
        if (rank_ok) begin
          lr = rank;
          while (lr <= NRANKS && !fl_head_ok[lr]) lr++;
          if (lr > NRANKS) begin
            st = ST_NOSPACE;
          end else begin
            while (lr > rank) begin
              idx = fl_pop(lr);
              lr--;
              fl_push(idx + bsize(lr), lr);
              fl_push(idx, lr);
            end
            v = fl_pop(rank);
            mark_span(v, rank, 1'b1);
            st = ST_OK;
          end
        end
      end
      CMD_FREE: begin
        if (page < pool_size && pg_mark[page] > 0) begin
          cr = pg_mark[page];
          idx = page;
          mark_span(idx, cr, 1'b0);
          while (cr < NRANKS) begin
            sz = bsize(cr);
            bud = idx ^ sz;
            if (bud + sz > pool_size) break;
            if (!span_free(bud, sz)) break;
            fl_unlink(bud, cr);
            if (bud < idx) idx = bud;
            cr++;
          end
          fl_push(idx, cr);
          st = ST_OK;
        end
      end
      CMD_QUERY: begin
        if (page < pool_size) begin
          if (pg_mark[page] > 0) begin
            v = pg_mark[page];
            st = ST_OK;
          end else begin
            for (int unsigned qr = NRANKS; qr >= 1; qr--) begin
              sz = bsize(qr);
              start = page & ~(sz - 1);
              if (start + sz > pool_size) continue;
              if (!span_free(start, sz)) continue;
              void'(fl_walk(qr, start, found));
              if (found) begin
                v = qr;
                st = ST_OK;
                break;
              end
            end
          end
        end
      end
      default: begin
        if (rank_ok) begin
          v = fl_walk(rank, 32'hFFFF_FFFF, found);
          st = ST_OK;
        end
      end
    endcase
    if (st != ST_OK) v = 0;
    val = v[15:0];
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [4:0] rank,
                          input logic [15:0] page);
    logic [1:0]  st;
    logic [15:0] val;
    if (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    rank_i       <= rank;
    page_index_i <= page;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    run_command(cmd, rank, page, st, val);
    exp_status_q.push_back(st);
    exp_value_q.push_back(val);
  endtask

  // drop valid in the step of the last acceptance, then let all results drain
  task automatic drain;
    in_valid_i <= 1'b0;
    while (exp_status_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_pool(input logic [15:0] pages);
    drain();
    cfg_valid_i  <= 1'b1;
    pool_pages_i <= pages;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    rebuild_pool(pages);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_status_q.size() == 0) begin
        $display("%0t: unexpected transaction status=%0d value=%0d", $time, status_o, value_o);
        err_count++;
      end else begin
        if (status_o !== exp_status_q[0]) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_status_q[0], status_o);
          err_count++;
        end
        if (value_o !== exp_value_q[0]) begin
          $display("%0t: value expected %0d actual %0d", $time, exp_value_q[0], value_o);
          err_count++;
        end
        void'(exp_status_q.pop_front());
        void'(exp_value_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // full reset pool: splitting, merging and argument checks
  task automatic test_reset_pool;
    send_cmd(CMD_COUNT, 5'd16, 16'd0);
    send_cmd(CMD_COUNT, 5'd0, 16'd0);
    send_cmd(CMD_COUNT, 5'd31, 16'hFFFF);
    send_cmd(CMD_ALLOC, 5'd1, 16'd0);
    send_cmd(CMD_QUERY, 5'd0, 16'd0);
    send_cmd(CMD_QUERY, 5'd0, 16'd1);
    send_cmd(CMD_ALLOC, 5'd16, 16'd0);
    send_cmd(CMD_ALLOC, 5'd0, 16'd0);
    send_cmd(CMD_ALLOC, 5'd17, 16'd0);
    send_cmd(CMD_ALLOC, 5'd3, 16'd0);
    send_cmd(CMD_FREE, 5'd0, 16'd5);
    send_cmd(CMD_FREE, 5'd0, 16'd3);
    send_cmd(CMD_FREE, 5'd0, 16'hFFFF);
    send_cmd(CMD_QUERY, 5'd0, 16'd32768);
    send_cmd(CMD_COUNT, 5'd1, 16'd0);
    send_cmd(CMD_FREE, 5'd0, 16'd0);
    send_cmd(CMD_FREE, 5'd0, 16'd4);
    send_cmd(CMD_COUNT, 5'd16, 16'd0);
    send_cmd(CMD_ALLOC, 5'd15, 16'd0);
    send_cmd(CMD_ALLOC, 5'd15, 16'd0);
    send_cmd(CMD_ALLOC, 5'd1, 16'd0);
  endtask

  // empty, single page and oversized pools
  task automatic test_pool_extremes;
    write_pool(16'd0);
    send_cmd(CMD_ALLOC, 5'd1, 16'd0);
    send_cmd(CMD_QUERY, 5'd0, 16'd0);
    send_cmd(CMD_COUNT, 5'd1, 16'd0);
    write_pool(16'd1);
    send_cmd(CMD_ALLOC, 5'd1, 16'd0);
    send_cmd(CMD_ALLOC, 5'd1, 16'd0);
    send_cmd(CMD_FREE, 5'd0, 16'd0);
    send_cmd(CMD_QUERY, 5'd0, 16'd0);
    write_pool(16'hFFFF);
    send_cmd(CMD_COUNT, 5'd16, 16'd0);
    send_cmd(CMD_QUERY, 5'd0, 16'd32767);
    write_pool(16'd37);
    send_cmd(CMD_ALLOC, 5'd6, 16'd0);
    send_cmd(CMD_ALLOC, 5'd3, 16'd0);
    send_cmd(CMD_QUERY, 5'd0, 16'd36);
    send_cmd(CMD_COUNT, 5'd1, 16'd0);
  endtask

  // mostly well-formed alloc/free traffic with queries, counts and noise
  task automatic test_random_traffic(input int unsigned n_items, input logic [15:0] pages);
    int unsigned sel, pg;
    write_pool(pages);
    for (int unsigned k = 0; k < n_items; k++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        send_cmd(CMD_ALLOC, ($urandom_range(9) == 0) ? 5'($urandom_range(1, 16))
                                                     : 5'($urandom_range(1, 5)),
                 16'($urandom));
      end else if (sel < 65) begin
        pg = (pool_size == 0) ? 0 : $urandom_range(pool_size - 1);
        for (int unsigned i = 0; i < pool_size; i++) begin
          if (pg_mark[(pg + i) % pool_size] > 0) begin
            pg = (pg + i) % pool_size;
            break;
          end
        end
        send_cmd(CMD_FREE, 5'($urandom), 16'(pg));
      end else if (sel < 85) begin
        send_cmd(CMD_QUERY, 5'($urandom),
                 (pool_size == 0) ? 16'd0 : 16'($urandom_range(pool_size - 1)));
      end else if (sel < 95) begin
        send_cmd(CMD_COUNT, 5'($urandom_range(1, 16)), 16'($urandom));
      end else begin
        send_cmd(2'($urandom), 5'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    pool_pages_i <= 16'd0;
    in_valid_i   <= 1'b0;
    command_i    <= CMD_ALLOC;
    rank_i       <= 5'd0;
    page_index_i <= 16'd0;
    rebuild_pool(POOL_RESET);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_pool();
    test_pool_extremes();
    test_random_traffic(250, 16'd200);
    calm = 1'b1;
    test_random_traffic(200, 16'($urandom_range(2, 300)));
    calm = 1'b0;
    test_random_traffic(200, 16'd64);
    test_random_traffic(200, 16'($urandom_range(300, 700)));
    test_random_traffic(150, 16'd5);
    drain();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
